@@ rtl/core/odcc_pkg.sv @@
// Package for the octree distinct colour counter: payload structs, controller
// state and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package odcc_pkg;

	localparam int NodePoolDef = 16384;
	localparam int TreeDepthDef = 8;
	localparam int ChanBits = 8;
	localparam int Slots = 8;
	localparam int CountW = 25;
	localparam logic [CountW-1:0] CountMax = 25'h1FFFFFF;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       first_pixel;
	} pixel_t;

	typedef struct packed {
		logic [CountW-1:0] distinct_count;
		logic              is_new_color;
		logic              pool_exhausted;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DECIDE,
		ST_GROW,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic follow;
		logic alloc;
		logic leaf;
		logic stop_full;
		logic grow;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
		logic full;
	} stat_t;

endpackage

@@ rtl/core/odcc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module odcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/odcc_datapath.sv @@
// Datapath of the octree distinct colour counter: pixel, walk position, node
// pool count, colour count, child and occupancy memories and result register.
// Depends on odcc_pkg and odcc_ram.
`timescale 1ns / 1ps

module odcc_datapath import odcc_pkg::*; #(
	parameter int NODE_POOL = NodePoolDef,
	parameter int TREE_DEPTH = TreeDepthDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output stat_t   st,
	input  pixel_t  pixel,
	output result_t result
);

	localparam int NW = $clog2(NODE_POOL);
	localparam int UW = $clog2(NODE_POOL + 1);
	localparam int LW = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
	localparam int CD = NODE_POOL * Slots;

	pixel_t            pix_q;
	logic [NW-1:0]     node_q;
	logic [LW-1:0]     level_q;
	logic [UW-1:0]     nodes_used_q;
	logic [CountW-1:0] count_q;
	logic              ovf_q;
	logic              is_new_q;
	logic [Slots-1:0]  root_mask_q;
	result_t           result_q;

	logic [2:0]       slot;
	logic [2:0]       sh;
	logic [Slots-1:0] onehot;
	logic [Slots-1:0] mask_rd;
	logic [Slots-1:0] cur_mask;
	logic [NW-1:0]    child_rd;
	logic             at_root;
	logic             mask_we;
	logic [Slots-1:0] mask_wdata;

	always_comb begin
		slot = '0;
		sh = '0;
		if (int'(level_q) < ChanBits) begin
			sh = 3'(ChanBits - 1 - int'(level_q));
			slot = {pix_q.blue[sh], pix_q.green[sh], pix_q.red[sh]};
		end
	end

	assign onehot = Slots'(1) << slot;
	assign at_root = (node_q == '0);
	assign cur_mask = at_root ? root_mask_q : mask_rd;

	assign st.hit = cur_mask[slot];
	assign st.last = (int'(level_q) == TREE_DEPTH - 1);
	assign st.full = (nodes_used_q >= UW'(NODE_POOL));

	assign mask_we = cmd.grow ? (cmd.alloc || cmd.leaf || cmd.stop_full)
	                          : (!at_root && (cmd.alloc || cmd.leaf));
	assign mask_wdata = cmd.stop_full ? '0 : (cmd.grow ? onehot : (cur_mask | onehot));

	odcc_ram #(
		.WIDTH(Slots),
		.DEPTH(NODE_POOL)
	) u_mask_ram (
		.clk  (clk),
		.we   (mask_we),
		.waddr(node_q),
		.wdata(mask_wdata),
		.raddr(node_q),
		.rdata(mask_rd)
	);

	odcc_ram #(
		.WIDTH(NW),
		.DEPTH(CD)
	) u_child_ram (
		.clk  (clk),
		.we   (cmd.alloc),
		.waddr({node_q, slot}),
		.wdata(nodes_used_q[NW-1:0]),
		.raddr({node_q, slot}),
		.rdata(child_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pix_q <= pixel;
		end
		if (cmd.load_out) begin
			result_q <= '{distinct_count: count_q, is_new_color: is_new_q,
			              pool_exhausted: ovf_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
			level_q <= '0;
			nodes_used_q <= UW'(1);
			count_q <= '0;
			ovf_q <= 1'b0;
			is_new_q <= 1'b0;
			root_mask_q <= '0;
		end else begin
			if (cmd.start) begin
				node_q <= '0;
				level_q <= '0;
				is_new_q <= 1'b0;
				if (pixel.first_pixel) begin
					nodes_used_q <= UW'(1);
					count_q <= '0;
					ovf_q <= 1'b0;
					root_mask_q <= '0;
				end
			end
			if (cmd.follow) begin
				node_q <= child_rd;
				level_q <= level_q + LW'(1);
			end
			if (cmd.alloc) begin
				node_q <= nodes_used_q[NW-1:0];
				nodes_used_q <= nodes_used_q + UW'(1);
				level_q <= level_q + LW'(1);
			end
			if (!cmd.grow && at_root && (cmd.alloc || cmd.leaf)) begin
				root_mask_q <= root_mask_q | onehot;
			end
			if (cmd.leaf) begin
				is_new_q <= 1'b1;
				if (count_q != CountMax) begin
					count_q <= count_q + CountW'(1);
				end
			end
			if (cmd.stop_full) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign result = result_q;

`ifndef SYNTHESIS
	a_pool_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q != '0 && nodes_used_q <= UW'(NODE_POOL))
		else $error("node pool count out of range");
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !st.full)
		else $error("allocation from a full pool");
	a_follow_child: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.follow |-> child_rd != '0)
		else $error("followed an occupied slot that holds the root");
	a_leaf_new: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.leaf |=> is_new_q)
		else $error("new colour not flagged");
`endif

endmodule

@@ rtl/core/odcc_ctrl.sv @@
// Controller of the octree distinct colour counter: walk state machine and
// request handshakes on both channels.
// Depends on odcc_pkg.
`timescale 1ns / 1ps

module odcc_ctrl import odcc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pixel_valid,
	output logic  pixel_ready,
	output logic  result_valid,
	input  logic  result_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pixel_valid) begin
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (st.hit) begin
					state_nxt = st.last ? ST_FINISH : ST_ISSUE;
				end else if (st.last || st.full) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_GROW;
				end
			end
			ST_GROW: begin
				if (st.last || st.full) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		pixel_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pixel_ready = 1'b1;
				cmd.start = pixel_valid;
			end
			ST_DECIDE: begin
				if (st.hit) begin
					cmd.follow = !st.last;
				end else if (st.last) begin
					cmd.leaf = 1'b1;
				end else if (st.full) begin
					cmd.stop_full = 1'b1;
				end else begin
					cmd.alloc = 1'b1;
				end
			end
			ST_GROW: begin
				cmd.grow = 1'b1;
				if (st.last) begin
					cmd.leaf = 1'b1;
				end else if (st.full) begin
					cmd.stop_full = 1'b1;
				end else begin
					cmd.alloc = 1'b1;
				end
			end
			ST_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

`ifndef SYNTHESIS
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.follow, cmd.alloc, cmd.leaf, cmd.stop_full, cmd.load_out}))
		else $error("more than one datapath action in a cycle");
	a_grow_walks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GROW |-> cmd.alloc || cmd.leaf || cmd.stop_full)
		else $error("growth step without an action");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || result_ready)
		else $error("result register overwritten before it was taken");
`endif

endmodule

@@ rtl/core/octree_distinct_color_counter.sv @@
// Top level of the octree distinct colour counter: controller and datapath.
// Depends on odcc_pkg, odcc_ctrl and odcc_datapath.
//
//   channel  | signals                                  | moves
//   ---------+------------------------------------------+----------------------------
//   pixel    | pixel_valid, pixel_ready, pixel (pixel_t) | one RGB request, in
//   result   | result_valid, result_ready, result       | one count request, out
//
// A request is accepted in ST_IDLE; each tree level whose node already exists
// takes an issue step and a decision step (one synchronous occupancy and child
// memory read, then the decision), each level below a newly allocated node a
// growth step, and a final step loads the result register.
// Reset leaves the root empty and the pool holding the root alone; no
// clearing pass is needed. A new pixel is taken while a result still waits;
// the walk then holds in its last step until that result has been taken.
`timescale 1ns / 1ps

module octree_distinct_color_counter import odcc_pkg::*; #(
	parameter int NODE_POOL = NodePoolDef,
	parameter int TREE_DEPTH = TreeDepthDef
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_ready,
	input  pixel_t  pixel,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	cmd_t  cmd;
	stat_t st;

	odcc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.st          (st),
		.cmd         (cmd)
	);

	odcc_datapath #(
		.NODE_POOL (NODE_POOL),
		.TREE_DEPTH(TREE_DEPTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.st    (st),
		.pixel (pixel),
		.result(result)
	);

endmodule

@@ tb/tb_octree_distinct_color_counter.sv @@
// Self-checking testbench for the octree distinct colour counter: a clocked driver and
// monitor around the block, with a software octree that predicts every count request.
// Depends on odcc_pkg and octree_distinct_color_counter.
`timescale 1ns / 1ps

module tb_octree_distinct_color_counter import odcc_pkg::*;;

	localparam int NodePool = NodePoolDef;
	localparam int TreeDepth = TreeDepthDef;
	localparam int FillPixels = 300;
	localparam int RandomPixels = 800;
	localparam int CalmItems = 300;
	localparam int HoldCycles = 400;
	localparam int SettleCycles = 60;
	localparam int ReportLimit = 10;

	typedef struct {
		pixel_t px;
		bit     wait_idle;
	} stim_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    pixel_valid = 1'b0;
	logic    pixel_ready;
	pixel_t  pixel = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	stim_t   pending[$];
	result_t awaited_tallies[$];
	pixel_t  fill_set [FillPixels];

	int unsigned       trie [NodePool * Slots];
	int unsigned       nodes_taken;
	logic [CountW-1:0] colour_total;
	logic              pool_spent;

	logic calm = 1'b0;
	logic hold_off = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   pixels_accepted = 0;
	int   tallies_checked = 0;
	int   new_colours_seen = 0;
	int   exhausted_seen = 0;
	int   mismatches = 0;

	octree_distinct_color_counter #(
		.NODE_POOL(NodePool),
		.TREE_DEPTH(TreeDepth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [2:0] branch_of(pixel_t p, int lvl);
		if (lvl >= ChanBits)
			return 3'd0;
		return {p.blue[ChanBits-1-lvl], p.green[ChanBits-1-lvl], p.red[ChanBits-1-lvl]};
	endfunction

	function automatic void restart_trie();
		for (int s = 0; s < Slots; s++)
			trie[s] = 0;
		nodes_taken = 1;
		colour_total = '0;
		pool_spent = 1'b0;
	endfunction

	function automatic void insert_colour(pixel_t p);
		int unsigned node;
		int unsigned at;
		int unsigned fresh;
		logic        reached;
		logic        is_new;
		result_t     tally;
		if (p.first_pixel)
			restart_trie();
		node = 0;
		reached = 1'b1;
		is_new = 1'b0;
		for (int lvl = 0; lvl < TreeDepth - 1; lvl++) begin
			at = node * Slots + branch_of(p, lvl);
			if (trie[at] == 0) begin
				if (nodes_taken >= NodePool) begin
					pool_spent = 1'b1;
					reached = 1'b0;
					break;
				end
				fresh = nodes_taken;
				nodes_taken++;
				for (int s = 0; s < Slots; s++)
					trie[fresh * Slots + s] = 0;
				trie[at] = fresh;
			end
			node = trie[at];
		end
		if (reached) begin
			at = node * Slots + branch_of(p, TreeDepth - 1);
			if (trie[at] == 0) begin
				trie[at] = 1;
				is_new = 1'b1;
				if (colour_total != CountMax)
					colour_total++;
			end
		end
		tally.distinct_count = colour_total;
		tally.is_new_color = is_new;
		tally.pool_exhausted = pool_spent;
		awaited_tallies.push_back(tally);
	endfunction

	function automatic void check_tally(result_t got);
		result_t want;
		if (awaited_tallies.size() == 0) begin
			mismatches++;
			if (mismatches <= ReportLimit)
				$display("%0t: unexpected result count=%0d new=%0b exhausted=%0b",
					$realtime, got.distinct_count, got.is_new_color, got.pool_exhausted);
			return;
		end
		want = awaited_tallies.pop_front();
		if (got.distinct_count !== want.distinct_count || got.is_new_color !== want.is_new_color
				|| got.pool_exhausted !== want.pool_exhausted) begin
			mismatches++;
			if (mismatches <= ReportLimit)
				$display("%0t: result %0d: count %0d/%0d new %0b/%0b exhausted %0b/%0b (exp/act)",
					$realtime, tallies_checked, want.distinct_count, got.distinct_count,
					want.is_new_color, got.is_new_color, want.pool_exhausted,
					got.pool_exhausted);
		end
	endfunction

	function automatic pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic first);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.first_pixel = first;
		return p;
	endfunction

	function automatic void queue_pixel(pixel_t p, bit wait_idle);
		stim_t s;
		s.px = p;
		s.wait_idle = wait_idle;
		pending.push_back(s);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel <= '0;
			send_gap <= 0;
		end else begin
			calm <= pending.size() < CalmItems;
			if (pixel_valid && pixel_ready) begin
				insert_colour(pixel);
				pixels_accepted++;
			end
			if (!pixel_valid || pixel_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					pixel_valid <= 1'b0;
				end else if (pending.size() != 0
						&& (!pending[0].wait_idle || awaited_tallies.size() == 0)) begin
					pixel <= pending[0].px;
					pixel_valid <= 1'b1;
					void'(pending.pop_front());
					if (!calm && $urandom_range(0, 3) == 0)
						send_gap <= $urandom_range(1, 6);
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_valid && result_ready) begin
				check_tally(result);
				tallies_checked++;
				if (result.is_new_color)
					new_colours_seen++;
				if (result.pool_exhausted)
					exhausted_seen++;
			end
			if (hold_off) begin
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 5);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		pixel_t px;
		pixel_t recent;
		pixel_t palette [8];
		logic [11:0] idx;
		int seg_left;
		int pick;
		bit restart;
		restart_trie();

		// Extremes of each channel, repeats, restarts and colours that differ only in
		// the lowest bit, so that only the last level of the tree is new.
		queue_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1), 1'b0);
		queue_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h00, 8'h00, 8'h01, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h01, 8'h00, 8'h00, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h00, 8'h01, 8'h00, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h80, 8'h80, 8'h80, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h7F, 8'h7F, 8'h7F, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1);
		queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
		queue_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h55, 8'hAA, 8'h0F, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'hAA, 8'h55, 8'hF0, 1'b0), 1'b0);
		queue_pixel(make_pixel(8'h55, 8'hAA, 8'h0F, 1'b0), 1'b0);

		// Every colour here has its own upper nibbles, so each one takes about four
		// fresh nodes and the tree grows wide quickly.
		for (int i = 0; i < FillPixels; i++) begin
			idx = i[11:0];
			fill_set[i] = make_pixel({idx[3:0], 4'($urandom)}, {idx[7:4], 4'($urandom)},
				{idx[11:8], 4'($urandom)}, i == 0);
			queue_pixel(fill_set[i], i == 0);
		end
		for (int i = 0; i < 60; i++) begin
			px = fill_set[$urandom_range(0, FillPixels - 1)];
			px.first_pixel = 1'b0;
			if ($urandom_range(0, 1))
				px.blue[0] = ~px.blue[0];
			queue_pixel(px, 1'b0);
		end
		for (int i = 0; i < 20; i++)
			queue_pixel(make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0), 1'b0);

		for (int i = 0; i < 8; i++)
			palette[i] = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		recent = palette[0];
		seg_left = 0;
		for (int i = 0; i < RandomPixels; i++) begin
			restart = seg_left == 0;
			if (restart)
				seg_left = $urandom_range(20, 200);
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				px = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
			end else if (pick < 8) begin
				px = palette[$urandom_range(0, 7)];
			end else begin
				px = recent;
				px.red = px.red ^ 8'($urandom_range(0, 3));
				px.green = px.green ^ 8'($urandom_range(0, 3));
				px.blue = px.blue ^ 8'($urandom_range(0, 3));
			end
			px.first_pixel = restart || $urandom_range(0, 149) == 0;
			queue_pixel(px, restart && $urandom_range(0, 2) == 0);
			recent = px;
			seg_left--;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : receiver_hold
		wait (pixels_accepted >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : finish_run
		@(posedge arst_n);
		while (pending.size() != 0 || pixel_valid)
			@(posedge clk);
		while (awaited_tallies.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		$display("%0d pixels inserted, %0d results checked, %0d new colours reported.",
			pixels_accepted, tallies_checked, new_colours_seen);
		$display("%0d results carried the exhausted pool flag; %0d mismatches.",
			exhausted_seen, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#1_500_000;
		$display("Timeout with %0d results outstanding.", awaited_tallies.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
